// ===== hdl/ledm_pkg.sv =====
// shared types, constants and helpers of the led matrix draw engine
package ledm_pkg;

  localparam int COLUMNS = 4;
  localparam int ROWS    = 4;
  localparam int PIXELS  = COLUMNS * ROWS;

  localparam int COL_W   = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int ADDR_W  = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam int COORD_W = 8;
  localparam int CHAN_W  = 8;
  localparam int PIX_W   = 3 * CHAN_W;
  localparam int LED_W   = 6;
  localparam int OP_W    = 4;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [PADDR_W-1:0] REG_BRIGHT_LIMIT = 3'd0;

  typedef enum logic [OP_W-1:0] {
    OP_SET_PIXEL = 4'd0,
    OP_GET_PIXEL = 4'd1,
    OP_FILL      = 4'd2,
    OP_CLEAR     = 4'd3,
    OP_ROW       = 4'd4,
    OP_COLUMN    = 4'd5,
    OP_HLINE     = 4'd6,
    OP_VLINE     = 4'd7,
    OP_RECT      = 4'd8,
    OP_FILL_RECT = 4'd9,
    OP_FLUSH     = 4'd10
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WRITE,
    S_READ,
    S_DRAIN
  } state_t;

  typedef struct packed {
    logic [COORD_W-1:0] lo;
    logic [COORD_W-1:0] hi;
  } span_t;

  typedef struct packed {
    logic [COL_W-1:0] x0;
    logic [COL_W-1:0] x1;
    logic [ROW_W-1:0] y0;
    logic [ROW_W-1:0] y1;
  } box_t;

  // order two endpoints, then clamp each to the last index
  function automatic span_t clamp_span(input logic [COORD_W-1:0] a,
                                       input logic [COORD_W-1:0] b,
                                       input logic [COORD_W-1:0] top);
    span_t s;
    s.lo = (a <= b) ? a : b;
    s.hi = (a <= b) ? b : a;
    if (s.lo > top) s.lo = top;
    if (s.hi > top) s.hi = top;
    return s;
  endfunction

  function automatic logic [CHAN_W-1:0] dim(input logic [CHAN_W-1:0] c,
                                            input logic lim);
    return lim ? {1'b0, c[CHAN_W-1:1]} : c;
  endfunction

endpackage

// ===== hdl/led_matrix_draw_engine.sv =====
// top level of the led matrix draw engine: command decode, scan sequencer, frame ram
//
//   channel   signals                          direction
//   cmd       cmd_valid cmd_ready op .. blue_in  into the block
//   res       res_valid res_ready kind .. last   out of the block
//   apb       psel penable pwrite paddr ...      register port
//
// a command holds the engine for its accept cycle and then while it walks every pixel of its box;
// the walk visits the pixels in turn, since the frame ram has a single write and a single read port.
// clear, unused codes and draws that miss the frame finish in the accept cycle.
// flush and get pixel read one pixel per cycle, then wait in a drain state for the last result,
// and stall while the result is not taken.
// reset blanks the frame at once through per-pixel valid bits; no clearing pass.
module led_matrix_draw_engine (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  output logic                          cmd_ready,
  input  logic [ledm_pkg::OP_W-1:0]     op,
  input  logic [ledm_pkg::COORD_W-1:0]  x_a,
  input  logic [ledm_pkg::COORD_W-1:0]  y_a,
  input  logic [ledm_pkg::COORD_W-1:0]  x_b,
  input  logic [ledm_pkg::COORD_W-1:0]  y_b,
  input  logic [ledm_pkg::CHAN_W-1:0]   red_in,
  input  logic [ledm_pkg::CHAN_W-1:0]   green_in,
  input  logic [ledm_pkg::CHAN_W-1:0]   blue_in,
  output logic                          res_valid,
  input  logic                          res_ready,
  output logic                          kind,
  output logic [ledm_pkg::LED_W-1:0]    strip_index,
  output logic [ledm_pkg::CHAN_W-1:0]   red_out,
  output logic [ledm_pkg::CHAN_W-1:0]   green_out,
  output logic [ledm_pkg::CHAN_W-1:0]   blue_out,
  output logic                          last,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ledm_pkg::PADDR_W-1:0]  paddr,
  input  logic [ledm_pkg::PDATA_W-1:0]  pwdata,
  output logic [ledm_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  import ledm_pkg::*;

  state_t             state;
  state_t             state_next;
  state_t             launch;
  box_t               box;
  box_t               box_new;
  logic [COL_W-1:0]   x;
  logic [ROW_W-1:0]   y;
  logic [PIX_W-1:0]   color;
  logic               outline;
  logic               outline_new;
  logic               flush_f;
  logic               flush_new;
  logic               zero_f;
  logic               zero_new;
  logic               clear_all;
  logic               bright_lim;
  logic [PIXELS-1:0]  pix_vld;
  span_t              span_x;
  span_t              span_y;
  logic               xa_ok;
  logic               ya_ok;
  logic               cmd_xfer;
  logic               scan_last;
  logic               on_edge;
  logic               mem_we;
  logic               issue;
  logic               take;
  logic               rd_pend;
  logic               rd_last;
  logic               rd_kind;
  logic               rd_vld;
  logic [LED_W-1:0]   rd_led;
  logic [ADDR_W-1:0]  addr;
  logic [ADDR_W-1:0]  led_pos;
  logic [PIX_W-1:0]   rdata;

  assign pready   = 1'b1;
  assign prdata   = (paddr == REG_BRIGHT_LIMIT) ? PDATA_W'(bright_lim) : '0;
  assign cmd_xfer = cmd_valid && cmd_ready;

  assign span_x = clamp_span(x_a, x_b, COORD_W'(COLUMNS - 1));
  assign span_y = clamp_span(y_a, y_b, COORD_W'(ROWS - 1));
  assign xa_ok  = x_a < COORD_W'(COLUMNS);
  assign ya_ok  = y_a < COORD_W'(ROWS);

  // command decode into a box, a walk mode and flags
  always_comb begin
    box_new     = '{x0: '0, x1: COL_W'(COLUMNS - 1), y0: '0, y1: ROW_W'(ROWS - 1)};
    launch      = S_IDLE;
    outline_new = 1'b0;
    flush_new   = 1'b0;
    zero_new    = 1'b0;
    clear_all   = 1'b0;
    case (op_t'(op))
      OP_SET_PIXEL: begin
        box_new = '{x0: COL_W'(x_a), x1: COL_W'(x_a), y0: ROW_W'(y_a), y1: ROW_W'(y_a)};
        if (xa_ok && ya_ok) launch = S_WRITE;
      end
      OP_GET_PIXEL: begin
        launch = S_READ;
        if (xa_ok && ya_ok) begin
          box_new = '{x0: COL_W'(x_a), x1: COL_W'(x_a), y0: ROW_W'(y_a), y1: ROW_W'(y_a)};
        end else begin
          box_new  = '{x0: '0, x1: '0, y0: '0, y1: '0};
          zero_new = 1'b1;
        end
      end
      OP_FILL: begin
        launch = S_WRITE;
      end
      OP_CLEAR: begin
        clear_all = 1'b1;
      end
      OP_ROW: begin
        box_new.y0 = ROW_W'(y_a);
        box_new.y1 = ROW_W'(y_a);
        if (ya_ok) launch = S_WRITE;
      end
      OP_COLUMN: begin
        box_new.x0 = COL_W'(x_a);
        box_new.x1 = COL_W'(x_a);
        if (xa_ok) launch = S_WRITE;
      end
      OP_HLINE: begin
        box_new = '{x0: COL_W'(span_x.lo), x1: COL_W'(span_x.hi),
                    y0: ROW_W'(y_a), y1: ROW_W'(y_a)};
        if (ya_ok) launch = S_WRITE;
      end
      OP_VLINE: begin
        box_new = '{x0: COL_W'(x_a), x1: COL_W'(x_a),
                    y0: ROW_W'(span_y.lo), y1: ROW_W'(span_y.hi)};
        if (xa_ok) launch = S_WRITE;
      end
      OP_RECT: begin
        box_new = '{x0: COL_W'(span_x.lo), x1: COL_W'(span_x.hi),
                    y0: ROW_W'(span_y.lo), y1: ROW_W'(span_y.hi)};
        outline_new = 1'b1;
        launch      = S_WRITE;
      end
      OP_FILL_RECT: begin
        box_new = '{x0: COL_W'(span_x.lo), x1: COL_W'(span_x.hi),
                    y0: ROW_W'(span_y.lo), y1: ROW_W'(span_y.hi)};
        launch  = S_WRITE;
      end
      OP_FLUSH: begin
        flush_new = 1'b1;
        launch    = S_READ;
      end
      default: begin
        launch = S_IDLE;
      end
    endcase
  end

  assign scan_last = (x == box.x1) && (y == box.y1);
  assign on_edge   = (x == box.x0) || (x == box.x1) || (y == box.y0) || (y == box.y1);
  assign addr      = ADDR_W'(y) * ADDR_W'(COLUMNS) + ADDR_W'(x);
  assign led_pos   = ADDR_W'(y) * ADDR_W'(COLUMNS)
                   + (y[0] ? ADDR_W'(COLUMNS - 1) - ADDR_W'(x) : ADDR_W'(x));

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (cmd_valid) state_next = launch;
      S_WRITE: if (scan_last) state_next = S_IDLE;
      S_READ:  if (issue && scan_last) state_next = S_DRAIN;
      S_DRAIN: if (take) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_ready = (state == S_IDLE);
    take      = rd_pend && (!res_valid || res_ready);
    mem_we    = (state == S_WRITE) && (!outline || on_edge);
    issue     = (state == S_READ) && (!rd_pend || take);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      bright_lim <= 1'b1;
      pix_vld    <= '0;
      rd_pend    <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (psel && penable && pwrite && pready && paddr == REG_BRIGHT_LIMIT) begin
        bright_lim <= pwdata[0];
      end
      if (cmd_xfer && clear_all) begin
        pix_vld <= '0;
      end else if (mem_we) begin
        pix_vld[addr] <= 1'b1;
      end
      if (issue) begin
        rd_pend <= 1'b1;
      end else if (take) begin
        rd_pend <= 1'b0;
      end
      if (take) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // scan walker and payload registers
  always_ff @(posedge clk) begin
    if (cmd_xfer) begin
      box     <= box_new;
      x       <= box_new.x0;
      y       <= box_new.y0;
      outline <= outline_new;
      flush_f <= flush_new;
      zero_f  <= zero_new;
      color   <= {dim(red_in, bright_lim), dim(green_in, bright_lim),
                  dim(blue_in, bright_lim)};
    end else if ((state == S_WRITE) || issue) begin
      if (x == box.x1) begin
        x <= box.x0;
        y <= y + 1'b1;
      end else begin
        x <= x + 1'b1;
      end
    end
    if (issue) begin
      rd_last <= scan_last;
      rd_kind <= flush_f;
      rd_led  <= flush_f ? LED_W'(led_pos) : '0;
      rd_vld  <= pix_vld[addr] && !zero_f;
    end
    if (take) begin
      kind        <= rd_kind;
      strip_index <= rd_led;
      last        <= rd_last;
      red_out     <= rd_vld ? rdata[PIX_W-1 -: CHAN_W] : '0;
      green_out   <= rd_vld ? rdata[2*CHAN_W-1 -: CHAN_W] : '0;
      blue_out    <= rd_vld ? rdata[CHAN_W-1:0] : '0;
    end
  end

  ledm_ram #(
    .WIDTH (PIX_W),
    .DEPTH (PIXELS)
  ) u_frame (
    .clk   (clk),
    .we    (mem_we),
    .waddr (addr),
    .wdata (color),
    .re    (issue),
    .raddr (addr),
    .rdata (rdata)
  );

`ifndef ASSERT_OFF
  a_we_only_drawing: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_WRITE))
    else $error("frame write outside a draw walk");

  a_pend_only_reading: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> (state == S_READ || state == S_DRAIN))
    else $error("read pending outside a read walk");

  a_drain_has_pending: assert property (@(posedge clk) disable iff (rst)
    (state == S_DRAIN) |-> rd_pend)
    else $error("drain state without a pending read");

  a_read_answer_shape: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !kind) |-> (last && strip_index == '0))
    else $error("pixel read answer with bad index or last");
`endif

endmodule

// ===== hdl/ledm_ram.sv =====
// generic single-port-write, registered-read ram
module ledm_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic                                        re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== tb/sv/ledm_frame_checker.sv =====
// frame model and result checker for the led matrix draw engine
module ledm_frame_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cmd_valid,
  input  logic                         cmd_ready,
  input  logic [ledm_pkg::OP_W-1:0]    op,
  input  logic [ledm_pkg::COORD_W-1:0] x_a,
  input  logic [ledm_pkg::COORD_W-1:0] y_a,
  input  logic [ledm_pkg::COORD_W-1:0] x_b,
  input  logic [ledm_pkg::COORD_W-1:0] y_b,
  input  logic [ledm_pkg::CHAN_W-1:0]  red_in,
  input  logic [ledm_pkg::CHAN_W-1:0]  green_in,
  input  logic [ledm_pkg::CHAN_W-1:0]  blue_in,
  input  logic                         res_valid,
  input  logic                         res_ready,
  input  logic                         kind,
  input  logic [ledm_pkg::LED_W-1:0]   strip_index,
  input  logic [ledm_pkg::CHAN_W-1:0]  red_out,
  input  logic [ledm_pkg::CHAN_W-1:0]  green_out,
  input  logic [ledm_pkg::CHAN_W-1:0]  blue_out,
  input  logic                         last,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ledm_pkg::PADDR_W-1:0] paddr,
  input  logic [ledm_pkg::PDATA_W-1:0] pwdata,
  input  logic [ledm_pkg::PDATA_W-1:0] prdata,
  input  logic                         pready,
  output int                           fail_count,
  output int                           waiting_items,
  output int                           items_checked
);
  import ledm_pkg::*;

  typedef struct packed {
    logic              kind;
    logic [LED_W-1:0]  led;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic              last;
  } led_item_t;

  logic [PIX_W-1:0] frame [PIXELS];
  logic             limit_on;
  led_item_t        expected_leds [$];
  led_item_t        head;

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  function automatic void sort_clamp(input int a, input int b, input int lim,
                                     output int lo, output int hi);
    lo = (a <= b) ? a : b;
    hi = (a <= b) ? b : a;
    if (lo >= lim) lo = lim - 1;
    if (hi >= lim) hi = lim - 1;
  endfunction

  task automatic paint(input int x0, input int x1, input int y0, input int y1,
                       input logic [PIX_W-1:0] c);
    for (int y = y0; y <= y1; y++)
      for (int x = x0; x <= x1; x++)
        frame[y * COLUMNS + x] = c;
  endtask

  task automatic push_led(input logic k, input int pos, input logic [PIX_W-1:0] c,
                          input logic l);
    led_item_t e;
    e.kind  = k;
    e.led   = pos[LED_W-1:0];
    e.red   = c[3*CHAN_W-1:2*CHAN_W];
    e.green = c[2*CHAN_W-1:CHAN_W];
    e.blue  = c[CHAN_W-1:0];
    e.last  = l;
    expected_leds.push_back(e);
  endtask

  task automatic draw_command(input logic [OP_W-1:0] code, input int xa, input int ya,
                              input int xb, input int yb, input logic [PIX_W-1:0] raw);
    logic [PIX_W-1:0] c;
    logic [PIX_W-1:0] seen;
    int x0, x1, y0, y1;
    c = limit_on ? {raw[23:16] >> 1, raw[15:8] >> 1, raw[7:0] >> 1} : raw;
    case (code)
      OP_SET_PIXEL: if (xa < COLUMNS && ya < ROWS) paint(xa, xa, ya, ya, c);
      OP_GET_PIXEL: begin
        seen = '0;
        if (xa < COLUMNS && ya < ROWS) seen = frame[ya * COLUMNS + xa];
        push_led(1'b0, 0, seen, 1'b1);
      end
      OP_FILL:  paint(0, COLUMNS - 1, 0, ROWS - 1, c);
      OP_CLEAR: paint(0, COLUMNS - 1, 0, ROWS - 1, '0);
      OP_ROW:    if (ya < ROWS) paint(0, COLUMNS - 1, ya, ya, c);
      OP_COLUMN: if (xa < COLUMNS) paint(xa, xa, 0, ROWS - 1, c);
      OP_HLINE: if (ya < ROWS) begin
        sort_clamp(xa, xb, COLUMNS, x0, x1);
        paint(x0, x1, ya, ya, c);
      end
      OP_VLINE: if (xa < COLUMNS) begin
        sort_clamp(ya, yb, ROWS, y0, y1);
        paint(xa, xa, y0, y1, c);
      end
      OP_RECT: begin
        sort_clamp(xa, xb, COLUMNS, x0, x1);
        sort_clamp(ya, yb, ROWS, y0, y1);
        paint(x0, x1, y0, y0, c);
        paint(x0, x1, y1, y1, c);
        paint(x0, x0, y0, y1, c);
        paint(x1, x1, y0, y1, c);
      end
      OP_FILL_RECT: begin
        sort_clamp(xa, xb, COLUMNS, x0, x1);
        sort_clamp(ya, yb, ROWS, y0, y1);
        paint(x0, x1, y0, y1, c);
      end
      OP_FLUSH: begin
        // odd rows run right to left on the strip
        for (int y = 0; y < ROWS; y++)
          for (int x = 0; x < COLUMNS; x++)
            push_led(1'b1, (y % 2 == 1) ? y * COLUMNS + COLUMNS - 1 - x : y * COLUMNS + x,
                     frame[y * COLUMNS + x], (y == ROWS - 1) && (x == COLUMNS - 1));
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      foreach (frame[i]) frame[i] = '0;
      limit_on = 1'b1;
      expected_leds.delete();
    end else begin
      if (psel && penable && pready && paddr == REG_BRIGHT_LIMIT) begin
        if (pwrite) limit_on = pwdata[0];
        else check_field("prdata", {31'b0, limit_on}, prdata);
      end
      if (res_valid && res_ready) begin
        if (expected_leds.size() == 0) begin
          $display("%0t: led item with none expected, actual kind %0d index %0d",
                   $time, kind, strip_index);
          $display("%0t:   actual rgb %h%h%h last %0d",
                   $time, red_out, green_out, blue_out, last);
          fail_count++;
        end else begin
          head = expected_leds.pop_front();
          check_field("kind", {31'b0, head.kind}, {31'b0, kind});
          check_field("strip_index", {26'b0, head.led}, {26'b0, strip_index});
          check_field("red_out", {24'b0, head.red}, {24'b0, red_out});
          check_field("green_out", {24'b0, head.green}, {24'b0, green_out});
          check_field("blue_out", {24'b0, head.blue}, {24'b0, blue_out});
          check_field("last", {31'b0, head.last}, {31'b0, last});
          items_checked++;
        end
      end
      if (cmd_valid && cmd_ready)
        draw_command(op, int'(x_a), int'(y_a), int'(x_b), int'(y_b),
                     {red_in, green_in, blue_in});
    end
    waiting_items = expected_leds.size();
  end

endmodule

// ===== tb/sv/led_matrix_draw_engine_test.sv =====
// testbench top for the led matrix draw engine: stimulus, register writes and verdict
module led_matrix_draw_engine_test;
  import ledm_pkg::*;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                cmd_valid = 1'b0;
  logic                cmd_ready;
  logic [OP_W-1:0]     op        = '0;
  logic [COORD_W-1:0]  x_a       = '0;
  logic [COORD_W-1:0]  y_a       = '0;
  logic [COORD_W-1:0]  x_b       = '0;
  logic [COORD_W-1:0]  y_b       = '0;
  logic [CHAN_W-1:0]   red_in    = '0;
  logic [CHAN_W-1:0]   green_in  = '0;
  logic [CHAN_W-1:0]   blue_in   = '0;
  logic                res_valid;
  logic                res_ready = 1'b0;
  logic                kind;
  logic [LED_W-1:0]    strip_index;
  logic [CHAN_W-1:0]   red_out;
  logic [CHAN_W-1:0]   green_out;
  logic [CHAN_W-1:0]   blue_out;
  logic                last;
  logic                psel      = 1'b0;
  logic                penable   = 1'b0;
  logic                pwrite    = 1'b0;
  logic [PADDR_W-1:0]  paddr     = '0;
  logic [PDATA_W-1:0]  pwdata    = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  int fail_count;
  int waiting_items;
  int items_checked;

  bit steady = 1'b0;
  int rx_hold = 0;
  int rx_wait = 0;
  bit rx_took = 1'b0;
  int cmds_sent = 0;
  int flushes_sent = 0;
  int reads_sent = 0;
  int reg_writes = 0;

  led_matrix_draw_engine dut (.*);
  ledm_frame_checker frame_check (.*);

  always #10 clk = ~clk;

  // result side: random stall per transfer, plus an optional long hold
  always @(posedge clk) rx_took <= res_valid && res_ready;

  always @(negedge clk) begin
    if (rx_took) rx_wait = steady ? 0 : $urandom_range(0, 3);
    if (rst) res_ready <= 1'b0;
    else if (rx_hold > 0) begin
      res_ready <= 1'b0;
      rx_hold = rx_hold - 1;
    end else if (rx_wait > 0) begin
      res_ready <= 1'b0;
      rx_wait = rx_wait - 1;
    end else res_ready <= 1'b1;
  end

  task automatic send_cmd(input logic [OP_W-1:0] code, input logic [7:0] xa,
                          input logic [7:0] ya, input logic [7:0] xb, input logic [7:0] yb,
                          input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    int gap;
    logic [31:0] noise;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      noise = $urandom;
      cmd_valid <= 1'b0;
      op <= noise[OP_W-1:0];
      x_a <= noise[11:4];
      y_a <= noise[19:12];
      red_in <= noise[27:20];
      repeat (gap) @(negedge clk);
    end
    cmd_valid <= 1'b1;
    op <= code;
    x_a <= xa;
    y_a <= ya;
    x_b <= xb;
    y_b <= yb;
    red_in <= r;
    green_in <= g;
    blue_in <= b;
    do @(posedge clk); while (!cmd_ready);
    @(negedge clk);
    cmds_sent++;
    if (code == OP_FLUSH) flushes_sent++;
    if (code == OP_GET_PIXEL) reads_sent++;
  endtask

  task automatic drain(input int settle);
    cmd_valid <= 1'b0;
    while (waiting_items != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  // write the brightness limit, then read it back
  task automatic set_limit(input logic value);
    logic [31:0] data;
    data = $urandom;
    data[0] = value;
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= REG_BRIGHT_LIMIT;
    pwdata <= data;
    @(negedge clk) penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk) penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    reg_writes++;
  endtask

  function automatic logic [7:0] pick_coord(input int lim);
    int v;
    case ($urandom_range(0, 3))
      0, 1:    v = $urandom_range(0, lim - 1);
      2:       v = $urandom_range(lim, 2 * lim + 3);
      default: v = $urandom_range(0, 255);
    endcase
    return v[7:0];
  endfunction

  function automatic logic [7:0] pick_chan();
    int v;
    case ($urandom_range(0, 7))
      0:       v = 0;
      1:       v = 255;
      default: v = $urandom_range(0, 255);
    endcase
    return v[7:0];
  endfunction

  task automatic random_cmd();
    int sel;
    int code;
    sel = $urandom_range(0, 99);
    if (sel < 4) code = $urandom_range(11, 15);
    else if (sel < 14) code = OP_FLUSH;
    else if (sel < 30) code = OP_GET_PIXEL;
    else if (sel < 42) code = OP_SET_PIXEL;
    else code = $urandom_range(0, 9);
    send_cmd(code[OP_W-1:0], pick_coord(COLUMNS), pick_coord(ROWS), pick_coord(COLUMNS),
             pick_coord(ROWS), pick_chan(), pick_chan(), pick_chan());
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // brightness limit at its reset value
    send_cmd(OP_GET_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0, 8'h00, 8'h00, 8'h00);
    send_cmd(OP_FLUSH, 8'd0, 8'd0, 8'd0, 8'd0, 8'h00, 8'h00, 8'h00);
    send_cmd(OP_SET_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0, 8'hff, 8'hff, 8'hff);
    send_cmd(OP_SET_PIXEL, 8'd3, 8'd3, 8'd0, 8'd0, 8'h01, 8'h80, 8'hfe);
    send_cmd(OP_SET_PIXEL, 8'd4, 8'd0, 8'd0, 8'd0, 8'h11, 8'h22, 8'h33);
    send_cmd(OP_SET_PIXEL, 8'd0, 8'd255, 8'd0, 8'd0, 8'h44, 8'h55, 8'h66);
    send_cmd(OP_GET_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0, 8'h00, 8'h00, 8'h00);
    send_cmd(OP_GET_PIXEL, 8'd3, 8'd3, 8'd0, 8'd0, 8'h00, 8'h00, 8'h00);
    send_cmd(OP_GET_PIXEL, 8'd255, 8'd255, 8'd0, 8'd0, 8'hff, 8'hff, 8'hff);
    drain(24);
    set_limit(1'b0);

    send_cmd(OP_FILL, 8'd0, 8'd0, 8'd0, 8'd0, 8'haa, 8'h55, 8'hff);
    send_cmd(OP_ROW, 8'd0, 8'd1, 8'd0, 8'd0, 8'h10, 8'h20, 8'h30);
    send_cmd(OP_ROW, 8'd0, 8'd4, 8'd0, 8'd0, 8'h01, 8'h01, 8'h01);
    send_cmd(OP_COLUMN, 8'd2, 8'd0, 8'd0, 8'd0, 8'h40, 8'h50, 8'h60);
    send_cmd(OP_COLUMN, 8'd200, 8'd0, 8'd0, 8'd0, 8'h02, 8'h02, 8'h02);
    send_cmd(OP_HLINE, 8'd255, 8'd2, 8'd1, 8'd0, 8'h70, 8'h80, 8'h90);
    send_cmd(OP_HLINE, 8'd0, 8'd9, 8'd3, 8'd0, 8'h03, 8'h03, 8'h03);
    send_cmd(OP_VLINE, 8'd0, 8'd3, 8'd0, 8'd0, 8'ha0, 8'hb0, 8'hc0);
    send_cmd(OP_VLINE, 8'd4, 8'd0, 8'd0, 8'd3, 8'h04, 8'h04, 8'h04);
    send_cmd(OP_RECT, 8'd200, 8'd0, 8'd250, 8'd2, 8'hd0, 8'he0, 8'hf0);
    send_cmd(OP_FILL_RECT, 8'd1, 8'd2, 8'd2, 8'd1, 8'h0f, 8'h1f, 8'h2f);
    send_cmd(4'd11, 8'd0, 8'd0, 8'd0, 8'd0, 8'hff, 8'hff, 8'hff);
    send_cmd(4'd15, 8'd1, 8'd1, 8'd1, 8'd1, 8'hff, 8'hff, 8'hff);
    send_cmd(OP_FLUSH, 8'd0, 8'd0, 8'd0, 8'd0, 8'h00, 8'h00, 8'h00);
    send_cmd(OP_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0, 8'hff, 8'hff, 8'hff);
    send_cmd(OP_FLUSH, 8'd0, 8'd0, 8'd0, 8'd0, 8'h00, 8'h00, 8'h00);

    for (int phase = 0; phase < 4; phase++) begin
      drain(24);
      set_limit(phase % 2 == 0);
      if (phase == 1) begin
        // hold the result side so the engine backs up into the command side
        rx_hold = 300;
        for (int j = 0; j < 8; j++)
          send_cmd((j % 2 == 1) ? OP_FLUSH : OP_GET_PIXEL, pick_coord(COLUMNS),
                   pick_coord(ROWS), 8'd0, 8'd0, 8'h00, 8'h00, 8'h00);
      end
      steady = (phase == 2);
      for (int i = 0; i < 112; i++) begin
        if (phase == 3 && i == 56) drain(0);
        random_cmd();
      end
      steady = 1'b0;
    end

    drain(24);
    $display("drove %0d commands including %0d flushes and %0d pixel reads",
             cmds_sent, flushes_sent, reads_sent);
    $display("checked %0d led items over %0d brightness register writes",
             items_checked, reg_writes);
    if (fail_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== led_matrix_draw_engine.f =====
hdl/ledm_pkg.sv
hdl/ledm_ram.sv
hdl/led_matrix_draw_engine.sv
tb/sv/ledm_frame_checker.sv
tb/sv/led_matrix_draw_engine_test.sv
